// ===== rtl/core/cwsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cwsc_pkg;

    localparam int OffsetBits = 48;
    localparam int CfgIndexBits = 3;

    localparam logic [CfgIndexBits-1:0] CFG_EXPECTED_STEP = 3'd0;
    localparam logic [CfgIndexBits-1:0] CFG_WRAP_PREVIOUS = 3'd1;
    localparam logic [CfgIndexBits-1:0] CFG_WRAP_CURRENT  = 3'd2;
    localparam logic [CfgIndexBits-1:0] CFG_MARKER_MASK   = 3'd3;
    localparam logic [CfgIndexBits-1:0] CFG_SECOND_BYTES  = 3'd4;

    localparam logic [31:0] RST_EXPECTED_STEP = 32'd131074;
    localparam logic [31:0] RST_WRAP_PREVIOUS = 32'd1;
    localparam logic [31:0] RST_WRAP_CURRENT  = 32'hFFFE_FFFF;
    localparam logic [31:0] RST_MARKER_MASK   = 32'h0000_FFFF;
    localparam logic [29:0] RST_SECOND_BYTES  = 30'd64000000;

    typedef enum logic [2:0] {
        ST_FIRST  = 3'd0,
        ST_STEP   = 3'd1,
        ST_WRAP   = 3'd2,
        ST_MARKER = 3'd3,
        ST_BAD    = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] expected_step;
        logic [31:0] wrap_previous;
        logic [31:0] wrap_current;
        logic [31:0] marker_mask;
        logic [29:0] second_bytes;
    } cwsc_cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] diff;
        logic        last_of_second;
    } cwsc_verdict_t;

    typedef struct packed {
        status_t     check_status;
        logic [47:0] byte_offset;
        logic [31:0] previous_value;
        logic [31:0] current_value;
        logic [31:0] step_found;
    } cwsc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/cwsc_judge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cwsc_judge
    import cwsc_pkg::*;
(
    input  cwsc_cfg_t     cfg,
    input  logic [31:0]   last_word,
    input  logic [31:0]   word,
    input  logic [29:0]   phase,
    output cwsc_verdict_t verdict
);

    logic [31:0] diff;
    logic [30:0] next_phase;
    logic        last_of_second;
    logic        wrap_hit;
    logic        marker_hit;

    always_comb
    begin
        diff           = last_word - word;
        next_phase     = {1'b0, phase} + 31'd4;
        last_of_second = next_phase >= {1'b0, cfg.second_bytes};
        wrap_hit       = (last_word == cfg.wrap_previous) && (word == cfg.wrap_current);
        marker_hit     = ((phase == 30'd0)
                          && ((last_word & cfg.marker_mask) == cfg.marker_mask))
                      || (last_of_second
                          && ((word & cfg.marker_mask) == cfg.marker_mask));
    end

    always_comb
    begin
        verdict.diff           = diff;
        verdict.last_of_second = last_of_second;
        if (diff == cfg.expected_step)
        begin
            verdict.status = ST_STEP;
        end
        else if (wrap_hit)
        begin
            verdict.status = ST_WRAP;
        end
        else if (marker_hit)
        begin
            verdict.status = ST_MARKER;
        end
        else
        begin
            verdict.status = ST_BAD;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/countdown_word_stream_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Checks a countdown test pattern one 32-bit word per cycle while in_stall is
// low. Each accepted word yields exactly one registered result word: status
// (first, step ok, wrap ok, marker excused, bad), byte offset of the previous
// word, both words and their difference. The subtract and compares sit between
// the stream state registers and the result register, so a word can be accepted
// every cycle; a one-entry skid behind the result register lets the input take
// one more word while the output is stalled, and in_stall rises only once it is
// full. Configuration is written through cfg_write/cfg_index/cfg_data while
// idle; writes to unused indexes are ignored.

module countdown_word_stream_checker_top
    import cwsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [31:0]             cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [31:0]             sample_word,
    input  logic                    stream_start,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              check_status,
    output logic [47:0]             byte_offset,
    output logic [31:0]             previous_value,
    output logic [31:0]             current_value,
    output logic [31:0]             step_found
);

    cwsc_cfg_t             cfg_reg;
    logic [31:0]           last_word_reg;
    logic                  awaiting_first_reg;
    logic [OffsetBits-1:0] offset_count_reg;
    logic [29:0]           second_phase_reg;

    cwsc_result_t          out_reg;
    cwsc_result_t          skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    cwsc_verdict_t         verdict;
    cwsc_result_t          result_next;
    logic                  in_accept;
    logic                  out_take;
    logic                  out_free;
    logic                  first_word;
    logic [63:0]           offset_wide;
    logic [30:0]           phase_sum;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_step <= RST_EXPECTED_STEP;
            cfg_reg.wrap_previous <= RST_WRAP_PREVIOUS;
            cfg_reg.wrap_current  <= RST_WRAP_CURRENT;
            cfg_reg.marker_mask   <= RST_MARKER_MASK;
            cfg_reg.second_bytes  <= RST_SECOND_BYTES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EXPECTED_STEP: cfg_reg.expected_step <= cfg_data;
                CFG_WRAP_PREVIOUS: cfg_reg.wrap_previous <= cfg_data;
                CFG_WRAP_CURRENT:  cfg_reg.wrap_current  <= cfg_data;
                CFG_MARKER_MASK:   cfg_reg.marker_mask   <= cfg_data;
                CFG_SECOND_BYTES:  cfg_reg.second_bytes  <= cfg_data[29:0];
                default:           ;
            endcase
        end
    end

    cwsc_judge u_judge (
        .cfg       (cfg_reg),
        .last_word (last_word_reg),
        .word      (sample_word),
        .phase     (second_phase_reg),
        .verdict   (verdict)
    );

    assign in_stall   = skid_valid_reg;
    assign in_accept  = in_valid && !skid_valid_reg;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || out_take;
    assign first_word = stream_start || awaiting_first_reg;

    always_comb
    begin
        offset_wide = 64'(offset_count_reg);
        phase_sum   = {1'b0, second_phase_reg} + 31'd4;
        if (first_word)
        begin
            result_next.check_status   = ST_FIRST;
            result_next.byte_offset    = '0;
            result_next.previous_value = '0;
            result_next.current_value  = sample_word;
            result_next.step_found     = '0;
        end
        else
        begin
            result_next.check_status   = verdict.status;
            result_next.byte_offset    = offset_wide[47:0];
            result_next.previous_value = last_word_reg;
            result_next.current_value  = sample_word;
            result_next.step_found     = verdict.diff;
        end
    end

    // stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_word_reg      <= '0;
            awaiting_first_reg <= 1'b1;
            offset_count_reg   <= '0;
            second_phase_reg   <= '0;
        end
        else if (in_accept)
        begin
            last_word_reg      <= sample_word;
            awaiting_first_reg <= 1'b0;
            if (first_word)
            begin
                offset_count_reg <= '0;
                second_phase_reg <= '0;
            end
            else
            begin
                offset_count_reg <= offset_count_reg + OffsetBits'(4);
                second_phase_reg <= verdict.last_of_second ? 30'd0 : phase_sum[29:0];
            end
        end
    end

    // result register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_accept)
            begin
                out_reg <= result_next;
            end
        end
        else if (in_accept)
        begin
            skid_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign check_status   = out_reg.check_status;
    assign byte_offset    = out_reg.byte_offset;
    assign previous_value = out_reg.previous_value;
    assign current_value  = out_reg.current_value;
    assign step_found     = out_reg.step_found;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the result register is empty");

    a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && first_word) |=> (offset_count_reg == '0 && second_phase_reg == '0))
        else $error("first word did not restart offset and phase");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_offset_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !first_word)
            |=> (offset_count_reg == $past(offset_count_reg) + OffsetBits'(4)))
        else $error("byte offset did not advance by one word");

endmodule

`default_nettype wire
